### hw/rtl/b64le_pkg.sv
// Shared types, constants and the base64 alphabet lookup for the line encoder.
package b64le_pkg;

   localparam logic [7:0] CHAR_PAD         = 8'h3D;
   localparam logic [7:0] CHAR_LF          = 8'h0A;
   localparam logic [7:0] LINE_CHARS_RESET = 8'd76;
   localparam logic [1:0] GROUP_BYTES_MAX  = 2'd2;
   localparam logic [2:0] LF_SLOT          = 3'd4;
   localparam logic [2:0] LAST_CHAR_SLOT   = 3'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } b64le_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_run;
   } b64le_rsp_type;

   // One finished group: four characters, first in slot 0, and the line-feed flag.
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic            line_feed;
   } b64le_group_type;

   function automatic logic [7:0] b64le_char(input logic [5:0] sextet);
      logic [7:0] v;
      v = {2'b00, sextet};
      if (sextet < 6'd26) begin
         return v + 8'd65;
      end else if (sextet < 6'd52) begin
         return v + 8'd71;
      end else if (sextet < 6'd62) begin
         return v - 8'd4;
      end else if (sextet == 6'd62) begin
         return 8'h2B;
      end else begin
         return 8'h2F;
      end
   endfunction

endpackage

### hw/rtl/b64le_front.sv
// Front end: gathers bytes into groups, encodes them and tracks the line length.
module b64le_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  b64le_pkg::b64le_req_type req_data,
   input  logic                     queue_full,
   input  logic [7:0]               line_chars,
   output logic                     queue_push,
   output b64le_pkg::b64le_group_type queue_data
);
   import b64le_pkg::*;

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  group_fill_ff, group_fill_in;
   logic [7:0]  line_count_ff, line_count_in;
   logic        accept;
   logic        close_group;
   logic [23:0] group_bits;
   logic [8:0]  count_sum;
   logic        line_feed;

   assign accept      = req_push && !queue_full;
   assign close_group = (group_fill_ff == GROUP_BYTES_MAX) || req_data.end_of_data;
   assign count_sum   = {1'b0, line_count_ff} + 9'd4;
   assign line_feed   = (count_sum >= {1'b0, line_chars}) || req_data.end_of_data;

   always_comb begin
      case (group_fill_ff)
         2'd0:    group_bits = {req_data.data_byte, 16'h0000};
         2'd1:    group_bits = {held_bytes_ff[15:8], req_data.data_byte, 8'h00};
         default: group_bits = {held_bytes_ff, req_data.data_byte};
      endcase
   end

   always_comb begin
      queue_data.chars[0]  = b64le_char(group_bits[23:18]);
      queue_data.chars[1]  = b64le_char(group_bits[17:12]);
      queue_data.chars[2]  = (group_fill_ff == 2'd0) ? CHAR_PAD
                                                     : b64le_char(group_bits[11:6]);
      queue_data.chars[3]  = (group_fill_ff != GROUP_BYTES_MAX) ? CHAR_PAD
                                                               : b64le_char(group_bits[5:0]);
      queue_data.line_feed = line_feed;
      queue_push           = accept && close_group;
   end

   always_comb begin
      held_bytes_in = held_bytes_ff;
      group_fill_in = group_fill_ff;
      line_count_in = line_count_ff;
      if (accept) begin
         if (close_group) begin
            held_bytes_in = 16'h0000;
            group_fill_in = 2'd0;
            line_count_in = line_feed ? 8'd0 : count_sum[7:0];
         end else begin
            if (group_fill_ff == 2'd0) begin
               held_bytes_in = {req_data.data_byte, 8'h00};
            end else begin
               held_bytes_in = {held_bytes_ff[15:8], req_data.data_byte};
            end
            group_fill_in = group_fill_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= 16'h0000;
         group_fill_ff <= 2'd0;
         line_count_ff <= 8'd0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         group_fill_ff <= group_fill_in;
         line_count_ff <= line_count_in;
      end
   end

endmodule

### hw/rtl/b64le_fifo.sv
// Short group queue between the front end and the character serializer.
module b64le_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  b64le_pkg::b64le_group_type push_data,
   input  logic                       pop,
   output logic                       full,
   output logic                       empty,
   output b64le_pkg::b64le_group_type head_data
);
   import b64le_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64le_group_type        slots_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slots_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/b64le_back.sv
// Back end: serializes each queued group into characters, one per transfer.
module b64le_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  b64le_pkg::b64le_group_type queue_head,
   output logic                       queue_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output b64le_pkg::b64le_rsp_type   rsp_data
);
   import b64le_pkg::*;

   logic [2:0] slot_ff, slot_in;
   logic [2:0] last_slot;
   logic       transfer;

   assign last_slot = queue_head.line_feed ? LF_SLOT : LAST_CHAR_SLOT;
   assign rsp_empty = queue_empty;
   assign transfer  = rsp_pop && !queue_empty;

   always_comb begin
      rsp_data.char_code  = (slot_ff == LF_SLOT) ? CHAR_LF : queue_head.chars[slot_ff[1:0]];
      rsp_data.end_of_run = (slot_ff == last_slot);
      queue_pop           = transfer && (slot_ff == last_slot);
      slot_in             = slot_ff;
      if (transfer) begin
         // advance through the group, drop it after its last character
         slot_in = (slot_ff == last_slot) ? 3'd0 : slot_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 3'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

endmodule

### hw/rtl/base64_line_encoder.sv
// Top level of the line-wrapped base64 encoder.
//
// Input queue port: raise req_push with a byte and its end_of_data flag; the
// byte is taken at an edge where req_full is low. Output queue port: while
// rsp_empty is low the oldest character is on rsp_data; rsp_pop takes it.
// csr_write_enable with csr_write_data sets the line length (reset 76); write
// it only while the encoder is idle.
// Every third byte (or the last byte of the data) closes a group, which yields
// four characters plus a line feed when the line is full or the data ends.
// A closing byte's group is registered in the group queue, and its first
// character shows on rsp_data once the group is at the queue head. Bytes are
// taken one per cycle while the group queue (QUEUE_DEPTH groups) has room, and
// characters drain one per cycle while rsp_pop is high. When the receiver
// stalls, the queue fills and req_full rises; nothing is dropped. Reset
// empties the queue, clears the partial group and line count.
module base64_line_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  b64le_pkg::b64le_req_type req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output b64le_pkg::b64le_rsp_type rsp_data,
   input  logic                     csr_write_enable,
   input  logic [7:0]               csr_write_data
);
   import b64le_pkg::*;

   logic [7:0]      line_chars_ff;
   logic [7:0]      line_chars_in;
   logic            queue_push;
   logic            queue_pop;
   logic            queue_empty;
   b64le_group_type queue_in_data;
   b64le_group_type queue_head;

   assign line_chars_in = csr_write_enable ? csr_write_data : line_chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_chars_ff <= LINE_CHARS_RESET;
      end else begin
         line_chars_ff <= line_chars_in;
      end
   end

   b64le_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .line_chars (line_chars_ff),
      .queue_push (queue_push),
      .queue_data (queue_in_data)
   );

   b64le_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_in_data),
      .pop       (queue_pop),
      .full      (req_full),
      .empty     (queue_empty),
      .head_data (queue_head)
   );

   b64le_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

### verif/tb.sv
// Self-checking testbench for the line-wrapped base64 encoder.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import b64le_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [7:0]      data_byte;
      logic            end_of_data;
      logic            typed;
      logic [2:0]      typed_count;
      logic [0:4][7:0] typed_chars;
   } stim_row_type;

   localparam stim_row_type DIRECTED_ROWS [22] = '{
      '{8'h00, 1'b1, 1'b1, 3'd5, {"AA==", CHAR_LF}},
      '{8'hFF, 1'b1, 1'b1, 3'd5, {"/w==", CHAR_LF}},
      '{8'hFF, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'hFF, 1'b1, 1'b1, 3'd5, {"//8=", CHAR_LF}},
      '{8'hFF, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'hFF, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'hFF, 1'b1, 1'b1, 3'd5, {"////", CHAR_LF}},
      '{8'h00, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'h00, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'h00, 1'b0, 1'b1, 3'd4, {"AAAA", 8'h00}},
      '{8'h4D, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'h61, 1'b0, 1'b1, 3'd0, 40'h0},
      '{8'h6E, 1'b0, 1'b1, 3'd4, {"TWFu", 8'h00}},
      '{8'h80, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'h01, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'h7E, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'h55, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'hAA, 1'b1, 1'b0, 3'd0, 40'h0},
      '{8'h3C, 1'b1, 1'b0, 3'd0, 40'h0},
      '{8'hC3, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'h0F, 1'b0, 1'b0, 3'd0, 40'h0},
      '{8'hF0, 1'b1, 1'b0, 3'd0, 40'h0}
   };

   logic          clock;
   logic          reset;
   logic          req_push;
   logic          req_full;
   b64le_req_type req_data;
   logic          rsp_empty;
   logic          rsp_pop;
   b64le_rsp_type rsp_data;
   logic          csr_write_enable;
   logic [7:0]    csr_write_data;

   // predictor state
   logic [15:0] held_bytes;
   logic [1:0]  group_fill;
   logic [7:0]  line_count;
   logic [7:0]  line_len;

   b64le_rsp_type pending_chars [$];
   int            failures;
   int            cycle_count;
   bit            send_steady;
   bit            sink_steady;

   base64_line_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data         (req_data),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("base64_line_encoder: mismatch");
         $finish;
      end
   end

   // Advance the encoder state by one byte; return the number of characters.
   function automatic int encode_byte(input logic [7:0] b, input logic eod,
                                      output logic [0:4][7:0] chars);
      logic [23:0] v;
      logic [8:0]  sum;
      int          n;
      chars = '0;
      if (group_fill < 2'd2 && !eod) begin
         if (group_fill == 2'd0) begin
            held_bytes = {b, 8'h00};
         end else begin
            held_bytes[7:0] = b;
         end
         group_fill = group_fill + 2'd1;
         return 0;
      end
      case (group_fill)
         2'd0:    v = {b, 16'h0000};
         2'd1:    v = {held_bytes[15:8], b, 8'h00};
         default: v = {held_bytes, b};
      endcase
      chars[0] = B64_ALPHABET[v[23:18]];
      chars[1] = B64_ALPHABET[v[17:12]];
      chars[2] = (group_fill >= 2'd1) ? B64_ALPHABET[v[11:6]] : CHAR_PAD;
      chars[3] = (group_fill == 2'd2) ? B64_ALPHABET[v[5:0]] : CHAR_PAD;
      // compare at nine bits so a long line never wraps the count
      sum = {1'b0, line_count} + 9'd4;
      if (sum >= {1'b0, line_len} || eod) begin
         chars[4] = CHAR_LF;
         n = 5;
         line_count = 8'd0;
      end else begin
         n = 4;
         line_count = sum[7:0];
      end
      held_bytes = 16'h0000;
      group_fill = 2'd0;
      return n;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eod, input logic typed,
                            input logic [2:0] typed_count,
                            input logic [0:4][7:0] typed_chars);
      logic [0:4][7:0] chars;
      int              n;
      int              gap;
      gap = send_steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{data_byte: b, end_of_data: eod};
      @(posedge clock);
      while (req_full) @(posedge clock);
      // transfer taken at this edge
      n = encode_byte(b, eod, chars);
      if (typed) begin
         n = typed_count;
         chars = typed_chars;
      end
      for (int k = 0; k < n; k++) begin
         pending_chars.push_back('{char_code: chars[k], end_of_run: (k == n - 1)});
      end
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), (i == len - 1), 1'b0, 3'd0, '0);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_line_length(input logic [7:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      line_len = value;
      csr_write_enable <= 1'b0;
   endtask

   // result side: random pop stalls, check every transfer
   initial begin
      b64le_rsp_type want;
      int            gap;
      rsp_pop <= 1'b0;
      sink_steady = 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) sink_steady = !sink_steady;
         gap = sink_steady ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         if (pending_chars.size() == 0) begin
            $error("unexpected result: char_code %h, end_of_run %b",
                   rsp_data.char_code, rsp_data.end_of_run);
            failures++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.char_code !== want.char_code) begin
               $error("char_code: expected %h, actual %h", want.char_code,
                      rsp_data.char_code);
               failures++;
            end
            if (rsp_data.end_of_run !== want.end_of_run) begin
               $error("end_of_run: expected %b, actual %b", want.end_of_run,
                      rsp_data.end_of_run);
               failures++;
            end
         end
      end
   end

   initial begin
      logic [7:0] line_settings [8];
      int         budget;
      int         len;
      reset            <= 1'b1;
      req_push         <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 8'd0;
      failures    = 0;
      cycle_count = 0;
      held_bytes  = 16'h0000;
      group_fill  = 2'd0;
      line_count  = 8'd0;
      line_len    = LINE_CHARS_RESET;
      send_steady = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].data_byte, DIRECTED_ROWS[i].end_of_data,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].typed_count,
                   DIRECTED_ROWS[i].typed_chars);
      end

      line_settings = '{8'd4, 8'd0, 8'd3, 8'd255, 8'd252,
                        8'($urandom_range(5, 40)), 8'($urandom_range(5, 251)),
                        LINE_CHARS_RESET};
      foreach (line_settings[p]) begin
         set_line_length(line_settings[p]);
         send_steady = (p % 3 == 1);
         // only one long run reaches the line end above 252
         if (line_settings[p] == 8'd255) send_message(200);
         budget = 16;
         while (budget > 0) begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
            if (len > budget) len = budget;
            send_message(len);
            budget -= len;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending_chars.size() == 0) begin
         $display("base64_line_encoder: match");
      end else begin
         $display("base64_line_encoder: mismatch");
      end
      $finish;
   end

endmodule
